@@ rtl/nco_cfs_pkg.sv @@
// Shared types and constants for the NCO complex frequency shifter.
// No dependencies; every other file of the block but the RAM refers to it by scoped names.
package nco_cfs_pkg;

    localparam int PHASE_STEPS_DEF  = 1000;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int SAMPLE_RATE_HZ   = 100000;

    // sine table entries are always Q1.15
    localparam int TABLE_W    = 16;
    localparam int FREQ_W     = 17;
    localparam int CFG_ADDR_W = 2;

    // widest phase index and step over the legal PHASE_STEPS range (up to 1024)
    localparam int PH_MAX_W   = 10;
    localparam int STEP_MAX_W = PH_MAX_W + 1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_FREQ   = 2'd1;

    // sine table write bus from the table builder
    typedef struct packed {
        logic                       we;
        logic [PH_MAX_W-1:0]        addr;
        logic signed [TABLE_W-1:0]  data;
    } t_tbl_wr;

    // configuration status seen by the datapath
    typedef struct packed {
        logic                         enable;
        logic                         busy;
        logic signed [STEP_MAX_W-1:0] step;
    } t_step_info;

endpackage

@@ rtl/nco_complex_frequency_shifter_unit.sv @@
// NCO complex frequency shifter: out = in * (cos + j*sin) of a rotating table phase.
// Beats are registered with their sin/cos table reads, then in the mixer output register;
// shift off or a zero step passes them through; one beat per cycle while tready stays high.
// After reset the serial table builder fills the sine table; no input beat is taken until then.
// s_axis_tready also drops in the cycle of a config write and the cycle after a freq write.
// Reset is synchronous, active low; config resets to shift off, frequency zero.
module nco_complex_frequency_shifter_unit #(
    parameter int PHASE_STEPS  = nco_cfs_pkg::PHASE_STEPS_DEF,
    parameter int SAMPLE_WIDTH = nco_cfs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // slave stream: tdata = {in_q, in_i}, in_i in the low bits, zero padded
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    // master stream: tdata = {out_q, out_i}, out_i in the low bits, zero padded
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,
    // config write channel: index 0 shift_enable, index 1 shift_freq
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [nco_cfs_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [nco_cfs_pkg::FREQ_W-1:0]          i_cfg_data
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int TDATA_W = ((2*SW+7)/8)*8;
    localparam int PH_W    = $clog2(PHASE_STEPS);
    localparam int TW      = nco_cfs_pkg::TABLE_W;
    localparam int QUARTER = PHASE_STEPS / 4;
    localparam logic signed [PH_W+1:0] P_S = (PH_W+2)'(PHASE_STEPS);

    nco_cfs_pkg::t_tbl_wr     tbl_wr;
    nco_cfs_pkg::t_step_info  info;
    logic                     tbl_done;

    // phase accumulator
    logic [PH_W-1:0]          r_phase;
    // stage 1: registered sample; sin/cos sit in the RAM read registers
    logic                     r_v1;
    logic                     r_byp1;
    logic signed [SW-1:0]     r_i1;
    logic signed [SW-1:0]     r_q1;
    // output register valid
    logic                     r_ov;

    logic                     adv_out;
    logic                     move12;
    logic                     accept;
    logic                     bypass;
    logic signed [PH_W:0]     step_s;
    logic signed [PH_W+1:0]   ph_sum;
    logic [PH_W-1:0]          ph_next;
    logic [PH_W:0]            kc_sum;
    logic [PH_W-1:0]          kc;
    logic [TW-1:0]            rd_sin;
    logic [TW-1:0]            rd_cos;
    logic signed [SW-1:0]     out_i;
    logic signed [SW-1:0]     out_q;

    // table builder fills the RAM once after reset
    nco_cfs_sine_gen #(
        .PHASE_STEPS (PHASE_STEPS)
    ) u_sine_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (tbl_wr),
        .o_done  (tbl_done)
    );

    // config registers and the derived phase step
    nco_cfs_step #(
        .PHASE_STEPS (PHASE_STEPS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_info      (info)
    );

    assign o_cfg_ready = 1'b1;

    // pipeline control: output slot frees when empty or drained this cycle
    assign adv_out = !r_ov || i_m_axis_tready;
    assign move12  = r_v1 && adv_out;
    // hold off samples until the table is built and the step settled; also on cfg or stalls
    assign o_s_axis_tready = tbl_done && !i_cfg_valid && !info.busy && (!r_v1 || adv_out);
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;

    assign step_s  = info.step[PH_W:0];
    assign bypass  = !info.enable || (step_s == '0);

    // next phase: |step| < PHASE_STEPS, so one correction wraps it
    assign ph_sum = $signed({2'b00, r_phase}) + (PH_W+2)'(step_s);
    always_comb begin
        if (ph_sum >= P_S) begin
            ph_next = PH_W'(ph_sum - P_S);
        end else if (ph_sum < 0) begin
            ph_next = PH_W'(ph_sum + P_S);
        end else begin
            ph_next = ph_sum[PH_W-1:0];
        end
    end

    // cosine is the sine a quarter period ahead
    assign kc_sum = {1'b0, r_phase} + (PH_W+1)'(QUARTER);
    assign kc = (kc_sum >= (PH_W+1)'(PHASE_STEPS)) ? PH_W'(kc_sum - (PH_W+1)'(PHASE_STEPS))
                                                    : kc_sum[PH_W-1:0];

    nco_cfs_ram #(
        .WIDTH (TW),
        .DEPTH (PHASE_STEPS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (tbl_wr.we),
        .i_waddr   (tbl_wr.addr[PH_W-1:0]),
        .i_wdata   (tbl_wr.data),
        .i_re      (accept),
        .i_raddr_a (r_phase),
        .i_raddr_b (kc),
        .o_rdata_a (rd_sin),
        .o_rdata_b (rd_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_v1    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
                // phase holds on passthrough samples
                if (!bypass) begin
                    r_phase <= ph_next;
                end
            end else if (move12) begin
                r_v1 <= 1'b0;
            end

            if (move12) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // stage 1 payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp1 <= bypass;
            r_i1   <= i_s_axis_tdata[SW-1:0];
            r_q1   <= i_s_axis_tdata[2*SW-1:SW];
        end
    end

    nco_cfs_mixer #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mixer (
        .i_clk    (i_clk),
        .i_load   (move12),
        .i_bypass (r_byp1),
        .i_si     (r_i1),
        .i_sq     (r_q1),
        .i_sin    (rd_sin),
        .i_cos    (rd_cos),
        .o_out_i  (out_i),
        .o_out_q  (out_q)
    );

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = TDATA_W'({out_q, out_i});

endmodule

@@ rtl/nco_cfs_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module nco_cfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

@@ rtl/nco_cfs_sine_gen.sv @@
// Sine table builder: after reset, computes every Q1.15 table entry with a
// folded Taylor series on one shared multiplier, divisions as reciprocal multiplies.
// Depends on nco_cfs_pkg.
module nco_cfs_sine_gen #(
    parameter int PHASE_STEPS = nco_cfs_pkg::PHASE_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    output nco_cfs_pkg::t_tbl_wr o_wr,
    output logic                 o_done
);

    localparam int PH_W = $clog2(PHASE_STEPS);

    // t = k * 2^32 / PHASE_STEPS, advanced by quotient plus remainder carry
    localparam logic [31:0] T_STEP = 32'((64'd1 << 32) / PHASE_STEPS);
    localparam logic [PH_W:0] T_REM = (PH_W+1)'((64'd1 << 32) % PHASE_STEPS);
    localparam logic [PH_W+1:0] T_MOD = (PH_W+2)'(PHASE_STEPS);
    localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;

    // ceil(2^(31+l) / b) for the odd factor b of each divisor, 2^(l-1) < b <= 2^l
    localparam logic [31:0] RCP_3  = 32'd2863311531;
    localparam logic [31:0] RCP_5  = 32'd3435973837;
    localparam logic [31:0] RCP_21 = 32'd3272356036;
    localparam logic [31:0] RCP_9  = 32'd3817748708;

    localparam logic [2:0] S_MUL_X  = 3'd0;
    localparam logic [2:0] S_MUL_X2 = 3'd1;
    localparam logic [2:0] S_MUL_T  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_ACC    = 3'd4;
    localparam logic [2:0] S_ROUND  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]      r_state;
    logic [PH_W-1:0] r_k;
    logic [31:0]     r_t;
    logic [PH_W:0]   r_trem;
    logic            r_neg;
    logic [31:0]     r_x;
    logic [31:0]     r_x2;
    logic [31:0]     r_term;
    logic [31:0]     r_sum;
    logic [31:0]     r_div;
    logic [1:0]      r_n;

    logic [31:0] t_half;
    logic [31:0] t_fold;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [31:0] mul_s;
    logic [31:0] div_a;
    logic [31:0] div_m;
    logic [31:0] div_q;
    logic [32:0] rnd_sum;
    logic [17:0] rnd_val;
    logic [15:0] rnd_mag;
    logic [PH_W+1:0] n_trem_sum;

    // quadrant folding
    assign t_half = r_t[31] ? {1'b0, r_t[30:0]} : r_t;
    assign t_fold = (t_half > 32'h4000_0000) ? (32'h8000_0000 - t_half) : t_half;

    always_comb begin
        case (r_state)
            S_MUL_X: begin
                mul_a = t_fold;
                mul_b = TWO_PI_Q28;
            end
            S_MUL_X2: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            S_DIV: begin
                mul_a = div_a;
                mul_b = div_m;
            end
            default: begin
                mul_a = r_term;
                mul_b = r_x2;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign mul_s = mul_p[61:30];

    // series divisors (2n)(2n+1) = 2^a * b: drop a bits, then multiply by the
    // reciprocal of b; exact for every 31-bit numerator
    always_comb begin
        case (r_n)
            2'd0: begin
                div_a = {1'b0, r_div[31:1]};
                div_m = RCP_3;
            end
            2'd1: begin
                div_a = {2'b00, r_div[31:2]};
                div_m = RCP_5;
            end
            2'd2: begin
                div_a = {1'b0, r_div[31:1]};
                div_m = RCP_21;
            end
            default: begin
                div_a = {3'b000, r_div[31:3]};
                div_m = RCP_9;
            end
        endcase
    end

    always_comb begin
        case (r_n)
            2'd0:    div_q = {1'b0, mul_p[63:33]};
            2'd1:    div_q = {2'b00, mul_p[63:34]};
            2'd2:    div_q = {4'b0000, mul_p[63:36]};
            default: div_q = {3'b000, mul_p[63:35]};
        endcase
    end

    assign rnd_sum = {1'b0, r_sum} + 33'h0_0000_4000;
    assign rnd_val = rnd_sum[32:15];
    assign rnd_mag = (rnd_val > 18'd32767) ? 16'd32767 : rnd_val[15:0];

    assign n_trem_sum = {1'b0, r_trem} + {1'b0, T_REM};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_MUL_X;
            r_k     <= '0;
            r_t     <= '0;
            r_trem  <= '0;
        end else begin
            case (r_state)
                S_MUL_X: begin
                    r_x     <= mul_s;
                    r_term  <= mul_s;
                    r_sum   <= mul_s;
                    r_neg   <= r_t[31];
                    r_state <= S_MUL_X2;
                end
                S_MUL_X2: begin
                    r_x2    <= mul_s;
                    r_n     <= 2'd0;
                    r_state <= S_MUL_T;
                end
                S_MUL_T: begin
                    r_div   <= mul_s;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_div   <= div_q;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_term <= r_div;
                    // odd terms subtract
                    r_sum  <= r_n[0] ? (r_sum + r_div) : (r_sum - r_div);
                    if (r_n == 2'd3) begin
                        r_state <= S_ROUND;
                    end else begin
                        r_n     <= r_n + 2'd1;
                        r_state <= S_MUL_T;
                    end
                end
                S_ROUND: begin
                    if (n_trem_sum >= T_MOD) begin
                        r_trem <= (PH_W+1)'(n_trem_sum - T_MOD);
                        r_t    <= r_t + T_STEP + 32'd1;
                    end else begin
                        r_trem <= n_trem_sum[PH_W:0];
                        r_t    <= r_t + T_STEP;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == PH_W'(PHASE_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL_X;
                    end
                end
                S_DONE: begin
                    r_state <= S_DONE;
                end
                default: begin
                    r_state <= S_MUL_X;
                end
            endcase
        end
    end

    always_comb begin
        o_wr.we   = (r_state == S_ROUND);
        o_wr.addr = nco_cfs_pkg::PH_MAX_W'(r_k);
        o_wr.data = r_neg ? -$signed(rnd_mag) : $signed(rnd_mag);
    end

    assign o_done = (r_state == S_DONE);

endmodule

@@ rtl/nco_cfs_step.sv @@
// Configuration registers and phase step: step = trunc(freq * PHASE_STEPS / rate),
// found by an exact reciprocal multiply of the registered product, then registered.
// Depends on nco_cfs_pkg.
module nco_cfs_step #(
    parameter int PHASE_STEPS = nco_cfs_pkg::PHASE_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [nco_cfs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [nco_cfs_pkg::FREQ_W-1:0]      i_cfg_data,
    output nco_cfs_pkg::t_step_info             o_info
);

    localparam int PH_W    = $clog2(PHASE_STEPS);
    localparam int FW      = nco_cfs_pkg::FREQ_W;
    localparam int PROD_W  = FW + $clog2(PHASE_STEPS + 1);
    localparam int DIV_SH  = PROD_W + $clog2(nco_cfs_pkg::SAMPLE_RATE_HZ);
    localparam int RECIP_W = DIV_SH - 16;
    // ceil(2^DIV_SH / rate); exact floor for every product below 2^PROD_W
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SH)
        + 64'(nco_cfs_pkg::SAMPLE_RATE_HZ) - 64'd1) / 64'(nco_cfs_pkg::SAMPLE_RATE_HZ));

    logic                       r_enable;
    logic                       r_neg;
    logic [PROD_W-1:0]          r_prod;
    logic signed [PH_W:0]       r_step;
    logic                       r_busy;

    logic [FW-1:0]              mag;
    logic [PROD_W+RECIP_W-1:0]  q_full;
    logic [PH_W:0]              q;

    assign mag    = i_cfg_data[FW-1] ? (~i_cfg_data + 1'b1) : i_cfg_data;
    assign q_full = (PROD_W+RECIP_W)'(r_prod) * (PROD_W+RECIP_W)'(RECIP);
    assign q      = {1'b0, q_full[DIV_SH +: PH_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_neg    <= 1'b0;
            r_prod   <= '0;
            r_step   <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    nco_cfs_pkg::REG_SHIFT_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                    end
                    nco_cfs_pkg::REG_SHIFT_FREQ: begin
                        r_neg  <= i_cfg_data[FW-1];
                        r_prod <= PROD_W'(mag) * PROD_W'(PHASE_STEPS);
                        r_busy <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            r_step <= r_neg ? -$signed(q) : $signed(q);
        end
    end

    always_comb begin
        o_info.enable = r_enable;
        o_info.busy   = r_busy;
        o_info.step   = nco_cfs_pkg::STEP_MAX_W'(r_step);
    end

endmodule

@@ rtl/nco_cfs_mixer.sv @@
// Complex multiply by the phasor, round half up, saturate, output register; bypass loads the input.
// Depends on nco_cfs_pkg.
module nco_cfs_mixer #(
    parameter int SAMPLE_WIDTH = nco_cfs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_load,
    input  logic                                     i_bypass,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_si,
    input  logic signed [SAMPLE_WIDTH-1:0]           i_sq,
    input  logic signed [nco_cfs_pkg::TABLE_W-1:0]   i_sin,
    input  logic signed [nco_cfs_pkg::TABLE_W-1:0]   i_cos,
    output logic signed [SAMPLE_WIDTH-1:0]           o_out_i,
    output logic signed [SAMPLE_WIDTH-1:0]           o_out_q
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int PROD_W = SW + nco_cfs_pkg::TABLE_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SH_W   = ACC_W - 15;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(16384);
    localparam logic signed [SH_W-1:0]  HI  = {{(SH_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [SH_W-1:0]  LO  = ~HI;

    logic signed [PROD_W-1:0] p_ic, p_qs, p_is, p_qc;
    logic signed [ACC_W-1:0]  acc_i, acc_q, b_i, b_q;
    logic signed [SH_W-1:0]   sh_i, sh_q;

    function automatic logic signed [SW-1:0] sat(input logic signed [SH_W-1:0] v);
        logic signed [SW-1:0] r;
        if (v > HI) begin
            r = HI[SW-1:0];
        end else if (v < LO) begin
            r = LO[SW-1:0];
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    assign p_ic = i_si * i_cos;
    assign p_qs = i_sq * i_sin;
    assign p_is = i_si * i_sin;
    assign p_qc = i_sq * i_cos;

    assign acc_i = ACC_W'(p_ic) - ACC_W'(p_qs);
    assign acc_q = ACC_W'(p_is) + ACC_W'(p_qc);
    assign b_i   = acc_i + RND;
    assign b_q   = acc_q + RND;
    assign sh_i  = b_i[ACC_W-1:15];
    assign sh_q  = b_q[ACC_W-1:15];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_out_i <= i_bypass ? i_si : sat(sh_i);
            o_out_q <= i_bypass ? i_sq : sat(sh_q);
        end
    end

endmodule

@@ rtl/nco_cfs_checker.sv @@
// Port-level checks for the NCO complex frequency shifter, bound to the top level.
// Depends on nco_cfs_pkg and the nco_complex_frequency_shifter_unit ports only.
module nco_cfs_checker #(
    parameter int SAMPLE_WIDTH = nco_cfs_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  i_s_axis_tdata,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  o_m_axis_tdata,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready,
    input logic [nco_cfs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input logic [nco_cfs_pkg::FREQ_W-1:0]       i_cfg_data
);

    logic s_beat;
    logic cfg_beat;

    assign s_beat   = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_beat = i_cfg_valid && o_cfg_ready;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    // no sample taken alongside a config write
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_beat |-> !o_s_axis_tready)
        else $error("sample accepted during config write");

    // after every input beat passes stage 1, the output register holds a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat |-> ##2 o_m_axis_tvalid)
        else $error("result missing two cycles after input beat");

    // a fresh result always comes from an input beat that has just passed stage 1
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(s_beat, 2))
        else $error("result without matching input beat");

endmodule

bind nco_complex_frequency_shifter_unit nco_cfs_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_checker (.*);

@@ dv/nco_complex_frequency_shifter_unit_tb.sv @@
// Testbench for the NCO complex frequency shifter: drives I/Q sample beats and
// config writes, and checks every output beat against an in-bench mixer predictor.
// Depends on rtl/nco_cfs_pkg.sv and rtl/nco_complex_frequency_shifter_unit.sv.
module nco_complex_frequency_shifter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = nco_cfs_pkg::SAMPLE_WIDTH_DEF;
    localparam int PHASE_STEPS = nco_cfs_pkg::PHASE_STEPS_DEF;
    localparam int RATE_HZ     = nco_cfs_pkg::SAMPLE_RATE_HZ;
    localparam int FREQ_W      = nco_cfs_pkg::FREQ_W;
    localparam int ADDR_W      = nco_cfs_pkg::CFG_ADDR_W;
    localparam int DATA_W      = ((2*SW+7)/8)*8;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 7;
    // covers the table build after reset plus a few hundred beats at worst-case gaps
    // and stalls, taken several times over
    localparam int CYCLE_LIMIT      = 400_000;
    localparam int SINK_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES      = 8;

    // 2*pi in Q28, used by the table series
    localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;

    localparam longint SMP_MAX = (longint'(1) << (SW-1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;

    // indexes with no register behind them; writes there must change nothing
    localparam logic [ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [ADDR_W-1:0] REG_SPARE_B = 2'd3;

    // one complex sample; i sits in the low half, matching the tdata layout
    typedef struct packed {
        logic signed [SW-1:0] q;
        logic signed [SW-1:0] i;
    } iq_t;

    logic              i_clk     = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_valid   = 1'b0;
    logic [DATA_W-1:0] s_data    = '0;
    logic              m_ready   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [ADDR_W-1:0] cfg_addr  = '0;
    logic [FREQ_W-1:0] cfg_data  = '0;

    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [DATA_W-1:0] o_m_axis_tdata;
    logic              o_cfg_ready;

    // mixer predictor state: its own copy of config and phase
    int                        sine_lut [PHASE_STEPS];
    logic                      mix_enable = 1'b0;
    logic signed [FREQ_W-1:0]  mix_freq   = '0;
    logic [9:0]                mix_phase  = '0;

    iq_t pending_iq [$];   // expected output beats, oldest first
    int  err_count  = 0;
    int  cycle_cnt  = 0;

    // idle control shared between the test tasks and the sink process
    bit  source_gaps = 1'b1;
    bit  sink_gaps   = 1'b1;
    bit  hold_sink   = 1'b0;

    nco_complex_frequency_shifter_unit #(
        .PHASE_STEPS  (PHASE_STEPS),
        .SAMPLE_WIDTH (SW)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #(CLK_PERIOD/2) i_clk = 1'b1;
        #(CLK_PERIOD/2) i_clk = 1'b0;
    end

    // Sine table in Q1.15: fold to the first quadrant, Q30 Taylor series up
    // to x^9, round half up to Q15, clip at +32767.
    initial begin : sine_lut_build
        longint unsigned t, x, x2, term, acc, r;
        bit neg;
        for (int k = 0; k < PHASE_STEPS; k++) begin
            neg = 1'b0;
            t = (longint'(k) << 32) / PHASE_STEPS;
            if (t >= 64'h8000_0000) begin
                neg = 1'b1;
                t -= 64'h8000_0000;
            end
            if (t > 64'h4000_0000) t = 64'h8000_0000 - t;
            x    = (t * TWO_PI_Q28) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 4; n++) begin
                term = ((term * x2) >> 30) / longint'((2*n) * (2*n+1));
                if (n % 2) acc -= term;
                else       acc += term;
            end
            r = (acc + 64'd16384) >> 15;
            if (r > 64'd32767) r = 64'd32767;
            sine_lut[k] = neg ? -int'(r) : int'(r);
        end
    end

    // add half an LSB, floor, clip to the sample range
    function automatic logic signed [SW-1:0] round_to_sample(input longint acc);
        longint r;
        r = (acc + (longint'(1) << 14)) >>> 15;
        if (r > SMP_MAX)      r = SMP_MAX;
        else if (r < SMP_MIN) r = SMP_MIN;
        return r[SW-1:0];
    endfunction

    // Mix one sample by the current phasor and advance the phase.
    // Disabled or zero step: pass through, phase held.
    function automatic iq_t rotate_sample(input iq_t din);
        iq_t    res;
        int     step, k, kc, nxt;
        longint s, c, si, sq;
        step = (int'(mix_freq) * PHASE_STEPS) / RATE_HZ;   // truncates toward zero
        if (!mix_enable || step == 0) return din;
        k  = mix_phase;
        kc = (k + PHASE_STEPS/4) % PHASE_STEPS;            // cosine = sine a quarter ahead
        s  = sine_lut[k];
        c  = sine_lut[kc];
        si = din.i;
        sq = din.q;
        res.i = round_to_sample(si*c - sq*s);
        res.q = round_to_sample(si*s + sq*c);
        nxt = k + step;
        if (nxt >= PHASE_STEPS) nxt -= PHASE_STEPS;
        else if (nxt < 0)       nxt += PHASE_STEPS;
        mix_phase = nxt[9:0];
        return res;
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SW'(SMP_MAX);
            1:       return SW'(SMP_MIN);
            default: return SW'($urandom);
        endcase
    endfunction

    // Offer one sample beat, with an optional random gap first. tvalid stays
    // high on return so back-to-back beats need no extra edge.
    task automatic send_iq(input logic signed [SW-1:0] si, input logic signed [SW-1:0] sq);
        iq_t smp;
        smp.i = si;
        smp.q = sq;
        if (source_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= DATA_W'(smp);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_iq.push_back(rotate_sample(smp));
    endtask

    // Stop offering and wait for every expected beat to come out.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_iq.size() != 0) @(posedge i_clk);
    endtask

    // One config beat; the predictor takes it at the handshake edge.
    // cfg_valid is left high so a following write needs no extra edge.
    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [FREQ_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            nco_cfs_pkg::REG_SHIFT_ENABLE: mix_enable = val[0];
            nco_cfs_pkg::REG_SHIFT_FREQ:   mix_freq   = val;
            default: ;
        endcase
    endtask

    // Only called with the block idle. Upper bits of the enable word are junk
    // on purpose: only bit 0 counts. Sometimes also pokes a spare index.
    task automatic set_config(input bit en, input logic signed [FREQ_W-1:0] freq);
        logic [FREQ_W-1:0] junk;
        junk = FREQ_W'($urandom);
        write_reg(nco_cfs_pkg::REG_SHIFT_ENABLE, {junk[FREQ_W-1:1], en});
        write_reg(nco_cfs_pkg::REG_SHIFT_FREQ, freq);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, FREQ_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // Reset config is shift off: extremes must come out untouched.
    task automatic test_bypass_after_reset();
        send_iq(16'sh7FFF, 16'sh8000);
        send_iq(16'sh8000, 16'sh7FFF);
        send_iq(16'sh0000, 16'sh0000);
        send_iq(16'shFFFF, 16'sh0001);
        send_iq(16'sh5555, 16'shAAAA);
        wait_results_drained();
    endtask

    // Enabled but |freq| < 100 gives a zero step: still pass through.
    // Spare register indexes are written here and must have no effect.
    task automatic test_zero_step();
        set_config(1'b1, 17'sd99);
        @(posedge i_clk);
        write_reg(REG_SPARE_A, 17'h1FFFF);
        write_reg(REG_SPARE_B, 17'h0AAAA);
        cfg_valid <= 1'b0;
        send_iq(16'sh7FFF, 16'sh7FFF);
        send_iq(16'sh8000, 16'sh8000);
        wait_results_drained();
        set_config(1'b1, -17'sd99);
        send_iq(16'sh1234, 16'shEDCB);
        wait_results_drained();
    endtask

    // Step 125 lands on 45 degrees, where full-scale inputs overflow and must
    // saturate. Disabling mid-way must freeze the phase, re-enabling resumes it.
    task automatic test_saturation_and_hold();
        set_config(1'b1, 17'sd12500);
        send_iq(16'sh8000, 16'sh8000);
        send_iq(16'sh8000, 16'sh8000);
        send_iq(16'sh7FFF, 16'sh7FFF);
        send_iq(16'sh7FFF, 16'sh8000);
        wait_results_drained();
        set_config(1'b0, 17'sd12500);
        send_iq(16'sh8000, 16'sh7FFF);
        send_iq(16'sh4000, 16'shC000);
        wait_results_drained();
        set_config(1'b1, 17'sd12500);
        send_iq(16'sh8000, 16'sh8000);
        send_iq(16'sh7FFF, 16'sh8000);
        wait_results_drained();
    endtask

    // Largest steps either way, beyond the nominal range, exercise both wraps.
    task automatic test_step_extremes();
        set_config(1'b1, 17'h0FFFF);
        repeat (3) send_iq(rand_sample(), rand_sample());
        wait_results_drained();
        set_config(1'b1, 17'h10000);
        repeat (3) send_iq(rand_sample(), rand_sample());
        wait_results_drained();
        set_config(1'b1, -17'sd50000);
        repeat (2) send_iq(rand_sample(), rand_sample());
        wait_results_drained();
    endtask

    // Bulk random traffic under several config settings, extremes included.
    task automatic test_random_settings();
        logic signed [FREQ_W-1:0] freq;
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 7))
                0:       freq = 17'h0FFFF;
                1:       freq = 17'h10000;
                2:       freq = 17'sd50000;
                3:       freq = -17'sd50000;
                4:       freq = FREQ_W'($urandom_range(0, 398)) - 17'sd199;
                default: freq = FREQ_W'($urandom);
            endcase
            set_config($urandom_range(0, 5) != 0, freq);
            repeat (65) send_iq(rand_sample(), rand_sample());
            wait_results_drained();
        end
    endtask

    // Sink stalls for a long stretch while beats keep coming: the pipeline
    // must fill, drop tready, and lose nothing.
    task automatic test_backpressure();
        source_gaps = 1'b0;
        hold_sink   = 1'b1;
        repeat (40) send_iq(rand_sample(), rand_sample());
        wait_results_drained();
        source_gaps = 1'b1;
    endtask

    // Full-rate stream with no idling on either side.
    task automatic test_steady_stream();
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        set_config(1'b1, FREQ_W'($urandom));
        repeat (60) send_iq(rand_sample(), rand_sample());
        wait_results_drained();
    endtask

    // ---------------------------------------------------------------- sink

    // m_tready: random stall bursts, or one long hold when a test asks.
    initial begin : sink_ready_gen
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                hold_sink = 1'b0;
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                m_ready <= 1'b1;
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each output beat, field by field, with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        iq_t got, want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            got = iq_t'(o_m_axis_tdata[2*SW-1:0]);
            if (pending_iq.size() == 0) begin
                $display("%0t: output beat with nothing expected, actual i=%0d q=%0d",
                         $time, got.i, got.q);
                err_count++;
            end else begin
                want = pending_iq.pop_front();
                if (got.i !== want.i) begin
                    $display("%0t: out_i expected %0d actual %0d", $time, want.i, got.i);
                    err_count++;
                end
                if (got.q !== want.q) begin
                    $display("%0t: out_q expected %0d actual %0d", $time, want.q, got.q);
                    err_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("nco_complex_frequency_shifter_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;

        // first beat waits out the table build through tready
        test_bypass_after_reset();
        test_zero_step();
        test_saturation_and_hold();
        test_step_extremes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("nco_complex_frequency_shifter_unit verification clean");
        else
            $display("nco_complex_frequency_shifter_unit verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/nco_cfs_pkg.sv
rtl/nco_cfs_ram.sv
rtl/nco_cfs_sine_gen.sv
rtl/nco_cfs_step.sv
rtl/nco_cfs_mixer.sv
rtl/nco_complex_frequency_shifter_unit.sv
rtl/nco_cfs_checker.sv
dv/nco_complex_frequency_shifter_unit_tb.sv
